>>> hdl/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg: shared types and microcode for the sparse polynomial evaluator
// Holds the command and result words, the control word layout and the
// read-only microprogram that sequences the datapath.
// ----------------------------------------------------------------------------
package spe_pkg;

	localparam int MAX_TERMS = 16;
	localparam int EXP_BITS  = 16;
	// Only the low EXP_BITS bits of the 16-bit exponent field take part.
	localparam int EXP_W     = (EXP_BITS < 16) ? EXP_BITS : 16;
	localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int PC_W      = 5;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_EVAL  = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic [15:0]        exponent;
		logic signed [63:0] coefficient;
		logic signed [63:0] x_value;
	} request_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic               status;
	} response_t;

	typedef logic [PC_W-1:0] upc_t;

	typedef enum logic [3:0] {
		OP_WAIT,
		OP_NOP,
		OP_CLEAR,
		OP_IDX_INIT,
		OP_SCAN_STEP,
		OP_WRITE_TERM,
		OP_TERM_INIT,
		OP_MUL_LL,
		OP_MUL_LH,
		OP_MUL_HL,
		OP_MUL_WR,
		OP_NEXT_IDX,
		OP_FINISH
	} uop_t;

	typedef enum logic [1:0] {
		MOP_ACC_SQ,
		MOP_SQ_SQ,
		MOP_COEF_ACC
	} mop_t;

	typedef enum logic [2:0] {
		JMP_NEVER,
		JMP_ALWAYS,
		JMP_IDX_MORE,
		JMP_NOT_VALID,
		JMP_E_ZERO,
		JMP_E_BIT0_CLR,
		JMP_E_UPPER_ZERO
	} jmp_t;

	typedef struct packed {
		uop_t op;
		mop_t mop;
		jmp_t jmp;
		upc_t target;
	} uword_t;

	localparam upc_t UA_IDLE     = upc_t'(0);
	localparam upc_t UA_DISPATCH = upc_t'(1);
	localparam upc_t UA_LSCAN    = upc_t'(5);
	localparam upc_t UA_ETERM    = upc_t'(7);
	localparam upc_t UA_EODD     = upc_t'(9);
	localparam upc_t UA_SQCHK    = upc_t'(14);
	localparam upc_t UA_ECOEF    = upc_t'(19);
	localparam upc_t UA_ENEXT    = upc_t'(23);
	localparam upc_t UA_FINISH   = upc_t'(24);

	function automatic uword_t uw(uop_t op, mop_t mop, jmp_t jmp, upc_t target);
		uword_t w;
		w.op     = op;
		w.mop    = mop;
		w.jmp    = jmp;
		w.target = target;
		return w;
	endfunction

	// The dispatch table at UA_DISPATCH is indexed by the command code.
	function automatic uword_t urom(upc_t a);
		uword_t w;
		unique case (a)
			upc_t'(0):  w = uw(OP_WAIT,       MOP_ACC_SQ,   JMP_NEVER,        UA_DISPATCH);
			upc_t'(1):  w = uw(OP_CLEAR,      MOP_ACC_SQ,   JMP_ALWAYS,       UA_FINISH);
			upc_t'(2):  w = uw(OP_IDX_INIT,   MOP_ACC_SQ,   JMP_ALWAYS,       UA_LSCAN);
			upc_t'(3):  w = uw(OP_IDX_INIT,   MOP_ACC_SQ,   JMP_ALWAYS,       UA_ETERM);
			upc_t'(4):  w = uw(OP_NOP,        MOP_ACC_SQ,   JMP_ALWAYS,       UA_FINISH);
			upc_t'(5):  w = uw(OP_SCAN_STEP,  MOP_ACC_SQ,   JMP_IDX_MORE,     UA_LSCAN);
			upc_t'(6):  w = uw(OP_WRITE_TERM, MOP_ACC_SQ,   JMP_ALWAYS,       UA_FINISH);
			upc_t'(7):  w = uw(OP_TERM_INIT,  MOP_ACC_SQ,   JMP_NOT_VALID,    UA_ENEXT);
			upc_t'(8):  w = uw(OP_NOP,        MOP_ACC_SQ,   JMP_E_ZERO,       UA_ECOEF);
			upc_t'(9):  w = uw(OP_NOP,        MOP_ACC_SQ,   JMP_E_BIT0_CLR,   UA_SQCHK);
			upc_t'(10): w = uw(OP_MUL_LL,     MOP_ACC_SQ,   JMP_NEVER,        UA_IDLE);
			upc_t'(11): w = uw(OP_MUL_LH,     MOP_ACC_SQ,   JMP_NEVER,        UA_IDLE);
			upc_t'(12): w = uw(OP_MUL_HL,     MOP_ACC_SQ,   JMP_NEVER,        UA_IDLE);
			upc_t'(13): w = uw(OP_MUL_WR,     MOP_ACC_SQ,   JMP_NEVER,        UA_IDLE);
			upc_t'(14): w = uw(OP_NOP,        MOP_SQ_SQ,    JMP_E_UPPER_ZERO, UA_ECOEF);
			upc_t'(15): w = uw(OP_MUL_LL,     MOP_SQ_SQ,    JMP_NEVER,        UA_IDLE);
			upc_t'(16): w = uw(OP_MUL_LH,     MOP_SQ_SQ,    JMP_NEVER,        UA_IDLE);
			upc_t'(17): w = uw(OP_MUL_HL,     MOP_SQ_SQ,    JMP_NEVER,        UA_IDLE);
			upc_t'(18): w = uw(OP_MUL_WR,     MOP_SQ_SQ,    JMP_ALWAYS,       UA_EODD);
			upc_t'(19): w = uw(OP_MUL_LL,     MOP_COEF_ACC, JMP_NEVER,        UA_IDLE);
			upc_t'(20): w = uw(OP_MUL_LH,     MOP_COEF_ACC, JMP_NEVER,        UA_IDLE);
			upc_t'(21): w = uw(OP_MUL_HL,     MOP_COEF_ACC, JMP_NEVER,        UA_IDLE);
			upc_t'(22): w = uw(OP_MUL_WR,     MOP_COEF_ACC, JMP_NEVER,        UA_IDLE);
			upc_t'(23): w = uw(OP_NEXT_IDX,   MOP_ACC_SQ,   JMP_IDX_MORE,     UA_ETERM);
			upc_t'(24): w = uw(OP_FINISH,     MOP_ACC_SQ,   JMP_ALWAYS,       UA_IDLE);
			default:    w = uw(OP_NOP,        MOP_ACC_SQ,   JMP_ALWAYS,       UA_IDLE);
		endcase
		return w;
	endfunction

endpackage

>>> hdl/sparse_polynomial_evaluator_core.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_evaluator_core
// Term table of sparse polynomial terms with clear, load and evaluate
// commands, run by a microprogram over one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
//
//  channel    ports                  direction  handshake
//  --------   --------------------   ---------  ------------------------------
//  command    start, busy, request   in         taken when start and not busy
//  result     done, response         out        one-cycle strobe, no stall
//
// One word in gives exactly one result word; no new word is taken before
// that result is shown. Evaluate time is set by the single 32x32
// multiplier: each 64-bit wrapping product takes four microcode steps.
// Reset empties the term table and returns the sequencer to idle. The
// receiver cannot stall; busy drops in the cycle the result is shown.
module sparse_polynomial_evaluator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  spe_pkg::request_t  request,
	output logic               done,
	output spe_pkg::response_t response
);

	localparam int NT = spe_pkg::MAX_TERMS;
	localparam int IW = spe_pkg::IDX_W;
	localparam int EW = spe_pkg::EXP_W;

	spe_pkg::upc_t   pc_q;
	spe_pkg::uword_t ucw;
	logic            jump;
	logic            accept;

	logic [NT-1:0]   valid_q;
	logic [EW-1:0]   exp_mem_q  [NT];
	logic [63:0]     coef_mem_q [NT];

	logic [IW-1:0]   idx_q;
	logic [IW-1:0]   hit_idx_q;
	logic [IW-1:0]   free_idx_q;
	logic            hit_f_q;
	logic            free_f_q;
	logic            status_q;
	logic            done_q;

	logic [EW-1:0]   e_q;
	logic [63:0]     cf_q;
	logic [63:0]     x_q;
	logic [63:0]     acc_q;
	logic [63:0]     sq_q;
	logic [63:0]     sum_q;
	logic [63:0]     m_q;
	logic [63:0]     p_q;
	spe_pkg::response_t response_q;

	logic [63:0]     opa;
	logic [63:0]     opb;
	logic [31:0]     mul_a;
	logic [31:0]     mul_b;
	logic [63:0]     mul_p;
	logic [63:0]     mres;
	logic            cur_valid;
	logic            scan_hit;
	logic            scan_free;
	logic            cf_nz;

	assign ucw       = spe_pkg::urom(pc_q);
	assign busy      = (pc_q != spe_pkg::UA_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign response  = response_q;
	assign cur_valid = valid_q[idx_q];
	assign scan_hit  = cur_valid && !hit_f_q && (exp_mem_q[idx_q] == e_q);
	assign scan_free = !cur_valid && !free_f_q;
	assign cf_nz     = (cf_q != 64'd0);

	always_comb begin
		unique case (ucw.jmp)
			spe_pkg::JMP_NEVER:        jump = 1'b0;
			spe_pkg::JMP_ALWAYS:       jump = 1'b1;
			spe_pkg::JMP_IDX_MORE:     jump = (idx_q != IW'(NT - 1));
			spe_pkg::JMP_NOT_VALID:    jump = !cur_valid;
			spe_pkg::JMP_E_ZERO:       jump = (e_q == '0);
			spe_pkg::JMP_E_BIT0_CLR:   jump = !e_q[0];
			spe_pkg::JMP_E_UPPER_ZERO: jump = ((e_q >> 1) == '0);
			default:                   jump = 1'b0;
		endcase
	end

	// Operand pair of the shared multiplier, fixed for all four product steps.
	always_comb begin
		unique case (ucw.mop)
			spe_pkg::MOP_ACC_SQ: begin
				opa = acc_q;
				opb = sq_q;
			end
			spe_pkg::MOP_SQ_SQ: begin
				opa = sq_q;
				opb = sq_q;
			end
			spe_pkg::MOP_COEF_ACC: begin
				opa = cf_q;
				opb = acc_q;
			end
			default: begin
				opa = acc_q;
				opb = sq_q;
			end
		endcase
	end

	// The low 64 bits of a 64x64 product need only low*low and the two
	// cross terms; the cross terms land in the upper half.
	always_comb begin
		unique case (ucw.op)
			spe_pkg::OP_MUL_LH: begin
				mul_a = opa[31:0];
				mul_b = opb[63:32];
			end
			spe_pkg::OP_MUL_HL: begin
				mul_a = opa[63:32];
				mul_b = opb[31:0];
			end
			default: begin
				mul_a = opa[31:0];
				mul_b = opb[31:0];
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign mres  = {p_q[63:32] + m_q[31:0], p_q[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= spe_pkg::UA_IDLE;
			valid_q    <= '0;
			idx_q      <= '0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			hit_f_q    <= 1'b0;
			free_f_q   <= 1'b0;
			status_q   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ucw.op == spe_pkg::OP_WAIT) begin
				if (start) begin
					pc_q     <= ucw.target + spe_pkg::upc_t'(request.command);
					status_q <= 1'b0;
				end
			end else if (jump) begin
				pc_q <= ucw.target;
			end else begin
				pc_q <= pc_q + spe_pkg::upc_t'(1);
			end

			unique case (ucw.op)
				spe_pkg::OP_CLEAR: begin
					valid_q <= '0;
				end
				spe_pkg::OP_IDX_INIT: begin
					idx_q    <= '0;
					hit_f_q  <= 1'b0;
					free_f_q <= 1'b0;
				end
				spe_pkg::OP_SCAN_STEP: begin
					idx_q <= idx_q + IW'(1);
					if (scan_hit) begin
						hit_f_q   <= 1'b1;
						hit_idx_q <= idx_q;
					end
					if (scan_free) begin
						free_f_q   <= 1'b1;
						free_idx_q <= idx_q;
					end
				end
				spe_pkg::OP_WRITE_TERM: begin
					if (cf_nz && !hit_f_q) begin
						if (free_f_q) begin
							valid_q[free_idx_q] <= 1'b1;
						end else begin
							status_q <= 1'b1;
						end
					end
				end
				spe_pkg::OP_NEXT_IDX: begin
					idx_q <= idx_q + IW'(1);
				end
				spe_pkg::OP_FINISH: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_q   <= request.exponent[EW-1:0];
			cf_q  <= request.coefficient;
			x_q   <= request.x_value;
			sum_q <= '0;
		end

		unique case (ucw.op)
			spe_pkg::OP_WRITE_TERM: begin
				if (cf_nz) begin
					if (hit_f_q) begin
						coef_mem_q[hit_idx_q] <= cf_q;
					end else if (free_f_q) begin
						exp_mem_q[free_idx_q]  <= e_q;
						coef_mem_q[free_idx_q] <= cf_q;
					end
				end
			end
			spe_pkg::OP_TERM_INIT: begin
				acc_q <= 64'd1;
				sq_q  <= x_q;
				e_q   <= exp_mem_q[idx_q];
				cf_q  <= coef_mem_q[idx_q];
			end
			spe_pkg::OP_MUL_LL: begin
				m_q <= mul_p;
			end
			spe_pkg::OP_MUL_LH: begin
				p_q <= m_q;
				m_q <= mul_p;
			end
			spe_pkg::OP_MUL_HL: begin
				p_q[63:32] <= p_q[63:32] + m_q[31:0];
				m_q        <= mul_p;
			end
			spe_pkg::OP_MUL_WR: begin
				unique case (ucw.mop)
					spe_pkg::MOP_ACC_SQ: begin
						acc_q <= mres;
					end
					spe_pkg::MOP_SQ_SQ: begin
						sq_q <= mres;
						e_q  <= e_q >> 1;
					end
					spe_pkg::MOP_COEF_ACC: begin
						sum_q <= sum_q + mres;
					end
					default: begin
					end
				endcase
			end
			spe_pkg::OP_FINISH: begin
				response_q.value  <= sum_q;
				response_q.status <= status_q;
			end
			default: begin
			end
		endcase
	end

endmodule
